@@ design/rles_pkg.sv @@
`default_nettype none
package rles_pkg;

  localparam int unsigned LevelW  = 7;
  localparam int unsigned PeriodW = 10;
  localparam int unsigned TimerW  = 16;
  localparam int unsigned ModeW   = 3;
  localparam int unsigned PhaseW  = 3;
  localparam int unsigned OpW     = 3;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned InDataW = 8;
  localparam int unsigned OutDataW = 32;

  // register reset values
  localparam logic [LevelW-1:0]  BreatheMaxRst  = 7'd80;
  localparam logic [LevelW-1:0]  BreatheMinRst  = 7'd5;
  localparam logic [LevelW-1:0]  OpenLevelRst   = 7'd65;
  localparam logic [PeriodW-1:0] FastPeriodRst  = 10'd20;
  localparam logic [PeriodW-1:0] SlowPeriodRst  = 10'd500;
  localparam logic [TimerW-1:0]  MenuTimeoutRst = 16'd10000;

  // effect modes
  localparam logic [ModeW-1:0] ModeWhite = 3'd0;
  localparam logic [ModeW-1:0] ModeRed   = 3'd1;
  localparam logic [ModeW-1:0] ModeGreen = 3'd2;
  localparam logic [ModeW-1:0] ModeBlue  = 3'd3;
  localparam logic [ModeW-1:0] ModeFlow  = 3'd4;
  localparam logic [ModeW-1:0] ModeCycle = 3'd5;
  localparam logic [ModeW-1:0] ModeOff   = 3'd6;
  localparam logic [ModeW-1:0] ModeKeep  = 3'd7;

  // flow and cycle phases with special handling
  localparam logic [PhaseW-1:0] PhaseLastFlow  = 3'd3;
  localparam logic [PhaseW-1:0] PhaseLastCycle = 3'd6;
  localparam logic [PhaseW-1:0] PhaseDark      = 3'd7;

  typedef enum logic [OpW-1:0] {
    OP_TICK       = 3'd0,
    OP_SET_MODE   = 3'd1,
    OP_NEXT_MODE  = 3'd2,
    OP_MENU_ENTER = 3'd3,
    OP_MENU_EXIT  = 3'd4
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BREATHE_MAX  = 3'd0,
    REG_BREATHE_MIN  = 3'd1,
    REG_OPEN_LEVEL   = 3'd2,
    REG_FAST_PERIOD  = 3'd3,
    REG_SLOW_PERIOD  = 3'd4,
    REG_MENU_TIMEOUT = 3'd5
  } reg_idx_e;

endpackage
`default_nettype wire

@@ design/rgb_led_effect_sequencer.sv @@
// Each result beat is registered and shows on the master side the cycle after its input beat.
// Throughput: one event per cycle; the state registers double as the result
// register, and a new beat is taken whenever that result is free or taken.
// Reset (rst_ni low, asynchronous): white breathing, levels at the breathe_min
// reset value, duties and menu timer zero, registers at their reset values.
`default_nettype none
module rgb_led_effect_sequencer
  import rles_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration write channel
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgW-1:0]     cfg_data_i,
  // event stream
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [InDataW-1:0]  s_axis_tdata,  // [2:0] new_mode, rest zero
  input  wire logic [OpW-1:0]      s_axis_tuser,  // [2:0] op
  // result stream
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [OutDataW-1:0]      m_axis_tdata   // [6:0] red_duty, [13:7] green_duty,
                                                  // [20:14] blue_duty, [23:21] mode_now,
                                                  // [24] menu_open, rest zero
);

  logic [LevelW-1:0]  breathe_max_q, breathe_min_q, open_level_q;
  logic [PeriodW-1:0] fast_period_q, slow_period_q;
  logic [TimerW-1:0]  menu_timeout_q;

  logic [ModeW-1:0]   mode_q, mode_d;
  logic [LevelW-1:0]  red_q, red_d, green_q, green_d, blue_q, blue_d;
  logic               rising_q, rising_d;
  logic [PeriodW-1:0] tick_q, tick_d;
  logic [PhaseW-1:0]  phase_q, phase_d;
  logic [TimerW-1:0]  timer_q, timer_d;
  logic [LevelW-1:0]  drv_r_q, drv_r_d, drv_g_q, drv_g_d, drv_b_q, drv_b_d;
  logic               menu_open_q;
  logic               out_valid_q;

  logic               s_accept;
  logic [ModeW-1:0]   req_mode;
  logic               enter;
  logic [PeriodW-1:0] period;
  logic [PeriodW:0]   tick_inc;
  logic               step;
  logic [PhaseW-1:0]  fp;
  logic [LevelW-1:0]  lvl;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign req_mode      = s_axis_tdata[ModeW-1:0];

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, menu_open_q, mode_q, drv_b_q, drv_g_q, drv_r_q};

  always_comb begin
    mode_d   = mode_q;
    red_d    = red_q;
    green_d  = green_q;
    blue_d   = blue_q;
    rising_d = rising_q;
    tick_d   = tick_q;
    phase_d  = phase_q;
    timer_d  = timer_q;
    drv_r_d  = drv_r_q;
    drv_g_d  = drv_g_q;
    drv_b_d  = drv_b_q;
    enter    = 1'b0;
    period   = (mode_q <= ModeFlow) ? fast_period_q : slow_period_q;
    tick_inc = {1'b0, tick_q} + {{PeriodW{1'b0}}, 1'b1};
    step     = tick_inc > {1'b0, period};
    fp       = (phase_q > PhaseLastFlow) ? '0 : phase_q;
    lvl      = red_q;

    case (s_axis_tuser)
      OP_TICK: begin
        if (timer_q != '0) timer_d = timer_q - TimerW'(1);
        if (mode_q <= ModeCycle) begin
          tick_d = step ? '0 : tick_inc[PeriodW-1:0];
          if (step) begin
            if (mode_q < ModeFlow) begin
              if (rising_q) begin
                if ({1'b0, red_q} + 8'd1 > {1'b0, breathe_max_q}) begin
                  rising_d = 1'b0;
                  lvl      = breathe_max_q;
                end else begin
                  lvl = red_q + LevelW'(1);
                end
              end else begin
                if (red_q == '0 || (red_q - LevelW'(1)) < breathe_min_q) begin
                  rising_d = 1'b1;
                  lvl      = breathe_min_q;
                end else begin
                  lvl = red_q - LevelW'(1);
                end
              end
              red_d   = lvl;
              drv_r_d = (mode_q == ModeWhite || mode_q == ModeRed)   ? lvl : '0;
              drv_g_d = (mode_q == ModeWhite || mode_q == ModeGreen) ? lvl : '0;
              drv_b_d = (mode_q == ModeWhite || mode_q == ModeBlue)  ? lvl : '0;
            end else if (mode_q == ModeFlow) begin
              // out-of-range phase restarts at phase 0
              phase_d = fp;
              case (fp)
                3'd0: begin
                  red_d = open_level_q;
                  if (green_q != '0)     green_d = green_q - LevelW'(1);
                  else if (blue_q != '0) blue_d  = blue_q - LevelW'(1);
                  else                   phase_d = 3'd1;
                end
                3'd1: begin
                  if (green_q < open_level_q) green_d = green_q + LevelW'(1);
                  else if (red_q != '0)       red_d   = red_q - LevelW'(1);
                  else                        phase_d = 3'd2;
                end
                3'd2: begin
                  if (blue_q < open_level_q) blue_d  = blue_q + LevelW'(1);
                  else if (green_q != '0)    green_d = green_q - LevelW'(1);
                  else                       phase_d = 3'd3;
                end
                default: begin
                  if (green_q < open_level_q)    green_d = green_q + LevelW'(1);
                  else if (red_q < open_level_q) red_d   = red_q + LevelW'(1);
                  else                           phase_d = 3'd0;
                end
              endcase
              drv_r_d = red_d;
              drv_g_d = green_d;
              drv_b_d = blue_d;
            end else begin
              red_d   = (phase_q == 3'd0 || phase_q == 3'd3 || phase_q == 3'd4 ||
                         phase_q == 3'd6) ? open_level_q : '0;
              green_d = (phase_q == 3'd1 || phase_q == 3'd3 || phase_q == 3'd5 ||
                         phase_q == 3'd6) ? open_level_q : '0;
              blue_d  = (phase_q == 3'd2 || phase_q == 3'd4 || phase_q == 3'd5 ||
                         phase_q == 3'd6) ? open_level_q : '0;
              drv_r_d = red_d;
              drv_g_d = green_d;
              drv_b_d = blue_d;
              if (phase_q == PhaseLastCycle) phase_d = '0;
              else if (phase_q == PhaseDark) phase_d = 3'd1;
              else                           phase_d = phase_q + PhaseW'(1);
            end
          end
        end
      end
      OP_SET_MODE: begin
        if (req_mode != ModeKeep) mode_d = req_mode;
        enter = 1'b1;
      end
      OP_NEXT_MODE: begin
        mode_d  = (mode_q >= ModeOff) ? ModeWhite : mode_q + ModeW'(1);
        timer_d = menu_timeout_q;
        tick_d  = '0;
        enter   = 1'b1;
      end
      OP_MENU_ENTER: timer_d = menu_timeout_q;
      OP_MENU_EXIT:  timer_d = '0;
      default: ;
    endcase

    // entry action of the (possibly unchanged) mode
    if (enter) begin
      if (mode_d < ModeFlow) begin
        red_d    = breathe_min_q;
        green_d  = breathe_min_q;
        blue_d   = breathe_min_q;
        rising_d = 1'b1;
        drv_r_d  = breathe_min_q;
        drv_g_d  = breathe_min_q;
        drv_b_d  = breathe_min_q;
      end else if (mode_d == ModeFlow) begin
        phase_d  = '0;
        rising_d = 1'b1;
        red_d    = open_level_q;
        green_d  = open_level_q;
        blue_d   = open_level_q;
        drv_r_d  = open_level_q;
        drv_g_d  = open_level_q;
        drv_b_d  = open_level_q;
      end else begin
        if (mode_d == ModeCycle) phase_d = '0;
        drv_r_d = '0;
        drv_g_d = '0;
        drv_b_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      breathe_max_q  <= BreatheMaxRst;
      breathe_min_q  <= BreatheMinRst;
      open_level_q   <= OpenLevelRst;
      fast_period_q  <= FastPeriodRst;
      slow_period_q  <= SlowPeriodRst;
      menu_timeout_q <= MenuTimeoutRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BREATHE_MAX:  breathe_max_q  <= cfg_data_i[LevelW-1:0];
        REG_BREATHE_MIN:  breathe_min_q  <= cfg_data_i[LevelW-1:0];
        REG_OPEN_LEVEL:   open_level_q   <= cfg_data_i[LevelW-1:0];
        REG_FAST_PERIOD:  fast_period_q  <= cfg_data_i[PeriodW-1:0];
        REG_SLOW_PERIOD:  slow_period_q  <= cfg_data_i[PeriodW-1:0];
        REG_MENU_TIMEOUT: menu_timeout_q <= cfg_data_i[TimerW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ModeWhite;
      red_q       <= BreatheMinRst;
      green_q     <= BreatheMinRst;
      blue_q      <= BreatheMinRst;
      rising_q    <= 1'b1;
      tick_q      <= '0;
      phase_q     <= '0;
      timer_q     <= '0;
      drv_r_q     <= '0;
      drv_g_q     <= '0;
      drv_b_q     <= '0;
      menu_open_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_accept) begin
        mode_q      <= mode_d;
        red_q       <= red_d;
        green_q     <= green_d;
        blue_q      <= blue_d;
        rising_q    <= rising_d;
        tick_q      <= tick_d;
        phase_q     <= phase_d;
        timer_q     <= timer_d;
        drv_r_q     <= drv_r_d;
        drv_g_q     <= drv_g_d;
        drv_b_q     <= drv_b_d;
        menu_open_q <= timer_d != '0;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        // drop the result once its beat is taken
        out_valid_q <= 1'b0;
      end
    end
  end

  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> m_axis_tvalid)
    else $error("accepted event produced no result");

  a_next_arms_menu: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && s_axis_tuser == OP_NEXT_MODE)
      |=> (menu_open_q == ($past(menu_timeout_q) != '0)))
    else $error("next-mode did not arm the menu timer");

  a_off_is_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && mode_q == ModeOff)
      |-> (drv_r_q == '0 && drv_g_q == '0 && drv_b_q == '0))
    else $error("off mode drives a nonzero duty");

  a_mode_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q != ModeKeep)
    else $error("effect mode reached the keep code");

endmodule
`default_nettype wire
